// ===== hdl/hsv2rgb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared widths, constants and types of the hsv to rgb converter.
// ----------------------------------------------------------------------------

package hsv2rgb_pkg;

  localparam int HUE_W    = 9;
  localparam int CHAN_W   = 8;
  localparam int REM_W    = 6;
  localparam int DROP_W   = 14;
  localparam int PNUM_W   = 16;
  localparam int LNUM_W   = 22;
  localparam int QUO_IN_W = 20;
  localparam int RECIP_W  = 21;
  localparam int PROD_W   = QUO_IN_W + RECIP_W;

  // tdata widths, padded to whole bytes
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 24;

  localparam logic [HUE_W-1:0]   HUE_TURN    = 9'd360;
  localparam logic [REM_W-1:0]   SECTOR_DEG  = 6'd60;
  localparam logic [CHAN_W-1:0]  CHAN_MAX    = 8'd255;
  localparam logic [DROP_W-1:0]  LEVEL_SCALE = 14'd15300;

  // floor(y / 3825) = (y * RECIP) >> 32 for every y below 2^20
  localparam logic [RECIP_W-1:0] RECIP_3825  = 21'd1122868;
  localparam int                 RECIP_SHIFT = 32;

  // hue sector, named after the hue range it spans
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

endpackage

// ===== hdl/hsv_to_rgb_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Five-stage pipelined hsv to rgb conversion with exact integer truncation.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one pixel per word: hue (degrees), saturation and
//   brightness. m_axis returns one word per pixel with red, green and blue.
//   Hue 360 and above is reduced by 360 before conversion.
//   Throughput is one pixel per clock; every stage is a register with its
//   own valid bit, so the pipeline takes a new word every cycle while the
//   output side keeps taking words.
//   Stages: hue reduce and sector split, small products, level numerators with
//   division by 255, reciprocal-multiply division by 15300, sector channel mux.
//   A stall on m_axis holds the output register; stages behind it keep
//   filling bubbles, so s_axis_tready stays high until all stages hold data.
//   Nothing is lost or repeated across a stall.
//   Synchronous reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------

module hsv_to_rgb_converter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // hue [8:0], saturation [16:9], brightness [24:17], zero pad
  input  logic [hsv2rgb_pkg::S_DATA_W-1:0] s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // red [7:0], green [15:8], blue [23:16]
  output logic [hsv2rgb_pkg::M_DATA_W-1:0] m_axis_tdata
);

  import hsv2rgb_pkg::*;

  localparam int NSTAGE = 5;

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] rdy;

  logic [HUE_W-1:0]  in_hue;
  logic [CHAN_W-1:0] in_sat;
  logic [CHAN_W-1:0] in_bright;

  // stage 1
  logic [HUE_W-1:0]  hue_red;
  logic [HUE_W-1:0]  sec_base;
  sector_t           sec_next;
  sector_t           s1_sector;
  logic [REM_W-1:0]  s1_rem;
  logic [CHAN_W-1:0] s1_sat;
  logic [CHAN_W-1:0] s1_bright;

  // stage 2
  sector_t           s2_sector;
  logic [DROP_W-1:0] s2_drop_q;
  logic [DROP_W-1:0] s2_drop_t;
  logic [PNUM_W-1:0] s2_p_num;
  logic [CHAN_W-1:0] s2_bright;

  // stage 3
  sector_t           s3_sector;
  logic [LNUM_W-1:0] s3_q_num;
  logic [LNUM_W-1:0] s3_t_num;
  logic [CHAN_W-1:0] s3_p;
  logic [CHAN_W-1:0] s3_bright;
  logic [PNUM_W:0]   p_sum;

  // stage 4
  logic [PROD_W-1:0] q_prod;
  logic [PROD_W-1:0] t_prod;
  sector_t           s4_sector;
  logic [CHAN_W-1:0] s4_q;
  logic [CHAN_W-1:0] s4_t;
  logic [CHAN_W-1:0] s4_p;
  logic [CHAN_W-1:0] s4_v;

  // stage 5
  logic [CHAN_W-1:0] red_next;
  logic [CHAN_W-1:0] green_next;
  logic [CHAN_W-1:0] blue_next;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  assign in_hue    = s_axis_tdata[HUE_W-1:0];
  assign in_sat    = s_axis_tdata[HUE_W+CHAN_W-1:HUE_W];
  assign in_bright = s_axis_tdata[HUE_W+2*CHAN_W-1:HUE_W+CHAN_W];

  // a stage loads when it is empty or its word moves on this cycle
  always_comb begin
    rdy[NSTAGE-1] = !vld[NSTAGE-1] || m_axis_tready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign s_axis_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // stage 1: fold hue into one turn, split into sector and remainder
  always_comb begin
    hue_red = (in_hue >= HUE_TURN) ? in_hue - HUE_TURN : in_hue;
    priority if (hue_red >= 9'd300) begin
      sec_next = SEC_MAG_RED;
      sec_base = 9'd300;
    end else if (hue_red >= 9'd240) begin
      sec_next = SEC_BLU_MAG;
      sec_base = 9'd240;
    end else if (hue_red >= 9'd180) begin
      sec_next = SEC_CYN_BLU;
      sec_base = 9'd180;
    end else if (hue_red >= 9'd120) begin
      sec_next = SEC_GRN_CYN;
      sec_base = 9'd120;
    end else if (hue_red >= 9'd60) begin
      sec_next = SEC_YEL_GRN;
      sec_base = 9'd60;
    end else begin
      sec_next = SEC_RED_YEL;
      sec_base = 9'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_sector <= sec_next;
      s1_rem    <= REM_W'(hue_red - sec_base);
      s1_sat    <= in_sat;
      s1_bright <= in_bright;
    end
  end

  // stage 2: saturation drops and the p numerator
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_sector <= s1_sector;
      s2_drop_q <= DROP_W'(s1_rem) * DROP_W'(s1_sat);
      s2_drop_t <= DROP_W'(SECTOR_DEG - s1_rem) * DROP_W'(s1_sat);
      s2_p_num  <= PNUM_W'(s1_bright) * PNUM_W'(CHAN_MAX - s1_sat);
      s2_bright <= s1_bright;
    end
  end

  // x / 255 for x up to 255 * 255, the largest p numerator
  assign p_sum = (PNUM_W+1)'(s2_p_num) + (PNUM_W+1)'(s2_p_num >> CHAN_W) + 17'd1;

  // stage 3: level numerators, p finished
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s3_sector <= s2_sector;
      s3_q_num  <= LNUM_W'(s2_bright) * LNUM_W'(LEVEL_SCALE - s2_drop_q);
      s3_t_num  <= LNUM_W'(s2_bright) * LNUM_W'(LEVEL_SCALE - s2_drop_t);
      s3_p      <= p_sum[PNUM_W-1:CHAN_W];
      s3_bright <= s2_bright;
    end
  end

  // stage 4: divide by 15300 as a shift by 2 then reciprocal multiply by 1/3825
  assign q_prod = PROD_W'(s3_q_num[LNUM_W-1:2]) * PROD_W'(RECIP_3825);
  assign t_prod = PROD_W'(s3_t_num[LNUM_W-1:2]) * PROD_W'(RECIP_3825);

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s4_sector <= s3_sector;
      s4_q      <= q_prod[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
      s4_t      <= t_prod[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
      s4_p      <= s3_p;
      s4_v      <= s3_bright;
    end
  end

  // stage 5: route levels to channels by sector
  always_comb begin
    unique case (s4_sector)
      SEC_RED_YEL: begin
        red_next = s4_v; green_next = s4_t; blue_next = s4_p;
      end
      SEC_YEL_GRN: begin
        red_next = s4_q; green_next = s4_v; blue_next = s4_p;
      end
      SEC_GRN_CYN: begin
        red_next = s4_p; green_next = s4_v; blue_next = s4_t;
      end
      SEC_CYN_BLU: begin
        red_next = s4_p; green_next = s4_q; blue_next = s4_v;
      end
      SEC_BLU_MAG: begin
        red_next = s4_t; green_next = s4_p; blue_next = s4_v;
      end
      default: begin
        red_next = s4_v; green_next = s4_p; blue_next = s4_q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

  assign m_axis_tvalid = vld[NSTAGE-1];
  assign m_axis_tdata  = {blue, green, red};

endmodule

// ===== tb/hsv_to_rgb_converter_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_check
// Watches both streams of the converter, works out the color for every
// accepted pixel word and compares each output word with the oldest one due.
// ----------------------------------------------------------------------------

module hsv_to_rgb_converter_check (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  // hue [8:0], saturation [16:9], brightness [24:17], zero pad
  input  logic [hsv2rgb_pkg::S_DATA_W-1:0] s_axis_tdata,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // red [7:0], green [15:8], blue [23:16]
  input  logic [hsv2rgb_pkg::M_DATA_W-1:0] m_axis_tdata,
  output int unsigned                      errors,
  output int unsigned                      pending
);

  import hsv2rgb_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  rgb_t        due_rgb_q[$];
  int unsigned err_cnt = 0;

  function automatic rgb_t convert_pixel(logic [HUE_W-1:0] hue_in,
                                         logic [CHAN_W-1:0] sat_in,
                                         logic [CHAN_W-1:0] bri_in);
    int unsigned       h, s, b, rem, p, q, t, v, scale, chan_max, deg;
    logic [CHAN_W-1:0] p8, q8, t8, v8;
    sector_t           sec;
    rgb_t              res;
    scale    = int'(LEVEL_SCALE);
    chan_max = int'(CHAN_MAX);
    deg      = int'(SECTOR_DEG);
    h = 32'(hue_in);
    s = 32'(sat_in);
    b = 32'(bri_in);
    // a full turn or more wraps back once
    if (h >= int'(HUE_TURN)) h = h - int'(HUE_TURN);
    sec = sector_t'(h / deg);
    rem = h % deg;
    p = (b * (chan_max - s)) / chan_max;
    q = (b * (scale - rem * s)) / scale;
    t = (b * (scale - (deg - rem) * s)) / scale;
    v = b;
    p8 = CHAN_W'(p);
    q8 = CHAN_W'(q);
    t8 = CHAN_W'(t);
    v8 = CHAN_W'(v);
    case (sec)
      SEC_RED_YEL: begin
        res.red = v8; res.green = t8; res.blue = p8;
      end
      SEC_YEL_GRN: begin
        res.red = q8; res.green = v8; res.blue = p8;
      end
      SEC_GRN_CYN: begin
        res.red = p8; res.green = v8; res.blue = t8;
      end
      SEC_CYN_BLU: begin
        res.red = p8; res.green = q8; res.blue = v8;
      end
      SEC_BLU_MAG: begin
        res.red = t8; res.green = p8; res.blue = v8;
      end
      default: begin
        res.red = v8; res.green = p8; res.blue = q8;
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t ns mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    rgb_t got, want;
    if (rst) begin
      due_rgb_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        due_rgb_q.push_back(convert_pixel(s_axis_tdata[8:0], s_axis_tdata[16:9],
                                          s_axis_tdata[24:17]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.red   = m_axis_tdata[7:0];
        got.green = m_axis_tdata[15:8];
        got.blue  = m_axis_tdata[23:16];
        if (due_rgb_q.size() == 0) begin
          report_mismatch("unexpected output word", m_axis_tdata, 0);
        end else begin
          want = due_rgb_q.pop_front();
          if (got.red !== want.red) report_mismatch("red", got.red, want.red);
          if (got.green !== want.green) report_mismatch("green", got.green, want.green);
          if (got.blue !== want.blue) report_mismatch("blue", got.blue, want.blue);
        end
      end
    end
    errors  <= err_cnt;
    pending <= due_rgb_q.size();
  end

endmodule

// ===== tb/hsv_to_rgb_converter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_test
// Drives pixel words into the converter, directed corners first and then
// random pixels in bursts, while the output side stalls in changing patterns.
// ----------------------------------------------------------------------------

module hsv_to_rgb_converter_test;
  import hsv2rgb_pkg::*;

  localparam int unsigned RANDOM_PIXELS = 1150;
  localparam int unsigned PAUSE_AT      = 600;
  localparam int unsigned TAIL_CYCLES   = 20;
  localparam int unsigned CYCLE_LIMIT   = 300000;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_COMB
  } rx_mode_t;

  logic                clk;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;

  int unsigned errors;
  int unsigned pending;
  int unsigned cycle_cnt = 0;

  rx_mode_t    rx_mode      = RX_OPEN;
  int unsigned rx_mode_left = 0;
  int unsigned rx_phase     = 0;

  logic [S_DATA_W-1:0] pixel_q[$];

  hsv_to_rgb_converter i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  hsv_to_rgb_converter_check i_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .errors        (errors),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [S_DATA_W-1:0] pack_pixel(logic [HUE_W-1:0] h,
                                                     logic [CHAN_W-1:0] s,
                                                     logic [CHAN_W-1:0] b);
    logic [S_DATA_W-1:0] w;
    w        = '0;
    w[8:0]   = h;
    w[16:9]  = s;
    w[24:17] = b;
    return w;
  endfunction

  function automatic logic [CHAN_W-1:0] edge_level();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  // sector borders and the wrap region
  function automatic logic [HUE_W-1:0] border_hue();
    int unsigned k;
    k = $urandom_range(0, 6);
    if ($urandom_range(0, 1)) return HUE_W'(k * 60);
    return (k == 0) ? HUE_W'(511) : HUE_W'(k * 60 - 1);
  endfunction

  // output side stall pattern, a new mode is drawn when the mode countdown runs out
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= rx_mode_t'($urandom_range(0, 3));
      rx_mode_left <= $urandom_range(16, 300);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    rx_phase <= rx_phase + 1;
    case (rx_mode)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_axis_tready <= ($urandom_range(0, 7) == 0);
      default:   m_axis_tready <= (rx_phase % 4 != 3);
    endcase
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned idx, burst_left, gap;
    logic [HUE_W-1:0]  h;
    logic [CHAN_W-1:0] s, b;

    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;

    // sector borders, wrap region, grey and black pixels
    pixel_q.push_back(pack_pixel(9'd0,   8'd255, 8'd255));
    pixel_q.push_back(pack_pixel(9'd59,  8'd255, 8'd255));
    pixel_q.push_back(pack_pixel(9'd60,  8'd255, 8'd255));
    pixel_q.push_back(pack_pixel(9'd119, 8'd200, 8'd255));
    pixel_q.push_back(pack_pixel(9'd120, 8'd255, 8'd128));
    pixel_q.push_back(pack_pixel(9'd179, 8'd255, 8'd255));
    pixel_q.push_back(pack_pixel(9'd180, 8'd100, 8'd255));
    pixel_q.push_back(pack_pixel(9'd239, 8'd255, 8'd77));
    pixel_q.push_back(pack_pixel(9'd240, 8'd255, 8'd255));
    pixel_q.push_back(pack_pixel(9'd299, 8'd1,   8'd254));
    pixel_q.push_back(pack_pixel(9'd300, 8'd255, 8'd255));
    pixel_q.push_back(pack_pixel(9'd359, 8'd255, 8'd255));
    pixel_q.push_back(pack_pixel(9'd360, 8'd255, 8'd255));
    pixel_q.push_back(pack_pixel(9'd419, 8'd255, 8'd255));
    pixel_q.push_back(pack_pixel(9'd420, 8'd170, 8'd200));
    pixel_q.push_back(pack_pixel(9'd511, 8'd255, 8'd255));
    pixel_q.push_back(pack_pixel(9'd511, 8'd0,   8'd0));
    pixel_q.push_back(pack_pixel(9'd77,  8'd0,   8'd255));
    pixel_q.push_back(pack_pixel(9'd200, 8'd0,   8'd93));
    pixel_q.push_back(pack_pixel(9'd333, 8'd255, 8'd0));
    pixel_q.push_back(pack_pixel(9'd30,  8'd128, 8'd1));
    pixel_q.push_back(pack_pixel(9'd0,   8'd0,   8'd0));

    for (idx = 0; idx < RANDOM_PIXELS; idx++) begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          h = border_hue();
          s = edge_level();
          b = edge_level();
        end
        3, 4, 5: begin
          h = HUE_W'($urandom_range(360, 511));
          s = CHAN_W'($urandom_range(0, 255));
          b = CHAN_W'($urandom_range(0, 255));
        end
        default: begin
          h = HUE_W'($urandom_range(0, 511));
          s = CHAN_W'($urandom_range(0, 255));
          b = CHAN_W'($urandom_range(0, 255));
        end
      endcase
      pixel_q.push_back(pack_pixel(h, s, b));
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    burst_left = 0;
    for (idx = 0; idx < pixel_q.size(); idx++) begin
      if (idx == PAUSE_AT) begin
        // let the pipeline drain completely before going on
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end else if (burst_left == 0) begin
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
        burst_left = $urandom_range(0, 5) == 0 ? $urandom_range(100, 250)
                                               : $urandom_range(1, 40);
        if (gap != 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      if (burst_left != 0) burst_left--;
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= pixel_q[idx];
      @(posedge clk);
      while (!s_axis_tready) @(posedge clk);
    end
    s_axis_tvalid <= 1'b0;
    // pending counts the last word only from the next edge on
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
